@@ sv/bcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_pkg
// Shared types and codes for the bounding box candidate selector.
// ----------------------------------------------------------------------------
package bcs_pkg;

  // Selection mode codes
  typedef enum logic [1:0] {
    MODE_FIRST   = 2'd0,
    MODE_CLOSEST = 2'd1,
    MODE_AREA    = 2'd2,
    MODE_SCORE   = 2'd3
  } sel_mode_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_SELECT_MODE  = 2'd0;
  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd2;

  localparam int unsigned MAX_FRAME_DIM = 8192;  // frame dimension clamp

  localparam int unsigned DimW  = 14;  // frame dimension / clipped size
  localparam int unsigned PosW  = 13;  // reported clipped origin
  localparam int unsigned Dist4W = 30; // full doubled-coordinate distance
  localparam int unsigned AreaW = 28;  // full clipped area

  // Candidate request as taken from the input channel
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [14:0]        width;
    logic [14:0]        height;
    logic               has_score;
    logic signed [31:0] score;
    logic               last;
  } cand_t;

  // Clipped candidate and its metrics
  typedef struct packed {
    logic               ok;
    logic [DimW-1:0]    x;
    logic [DimW-1:0]    y;
    logic [DimW-1:0]    w;
    logic [DimW-1:0]    h;
    logic [Dist4W-1:0]  d4;
    logic [AreaW-1:0]   area;
    logic               has_score;
    logic signed [31:0] score;
    logic               last;
  } metric_t;

  // Result request
  typedef struct packed {
    logic            found;
    logic [PosW-1:0] left;
    logic [PosW-1:0] top;
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
  } result_t;

endpackage

@@ sv/bcs_metric.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_metric
// Clips a candidate to the frame and registers its center distance and area.
// ----------------------------------------------------------------------------
module bcs_metric
  import bcs_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cand_valid,
  input  cand_t           cand,
  output logic            cand_ready,
  input  logic [DimW-1:0] frame_w,
  input  logic [DimW-1:0] frame_h,
  output logic            met_valid,
  output metric_t         met,
  input  logic            met_ready
);

  typedef struct packed {
    logic            ok;
    logic [DimW-1:0] start;
    logic [DimW-1:0] size;
  } axis_t;

  // Clip [lo, lo+len) to [0, lim)
  function automatic axis_t clip_axis(input logic signed [15:0] lo,
                                      input logic [14:0] len,
                                      input logic [DimW-1:0] lim);
    logic signed [17:0] a;
    logic signed [17:0] b;
    logic signed [17:0] l;
    logic signed [17:0] d;
    axis_t r;
    a = lo[15] ? 18'sd0 : $signed({2'b00, lo});
    b = $signed({{2{lo[15]}}, lo}) + $signed({3'b000, len});
    l = $signed({4'b0000, lim});
    if (b > l) begin
      b = l;
    end
    d = b - a;
    r.ok    = (b > a);
    r.start = r.ok ? a[DimW-1:0] : '0;
    r.size  = r.ok ? d[DimW-1:0] : '0;
    return r;
  endfunction

  axis_t              ax, ay;
  logic signed [16:0] dx, dy;
  logic signed [33:0] sqx, sqy;
  logic [AreaW-1:0]   area;
  metric_t            met_nxt;
  metric_t            met_r;
  logic               met_valid_r;

  always_comb begin
    ax   = clip_axis(cand.left, cand.width, frame_w);
    ay   = clip_axis(cand.top, cand.height, frame_h);
    // doubled offset of the box center from the frame center
    dx   = $signed({2'b00, ax.start, 1'b0}) + $signed({3'b000, ax.size})
           - $signed({3'b000, frame_w});
    dy   = $signed({2'b00, ay.start, 1'b0}) + $signed({3'b000, ay.size})
           - $signed({3'b000, frame_h});
    sqx  = dx * dx;
    sqy  = dy * dy;
    area = ax.size * ay.size;

    met_nxt.ok        = ax.ok && ay.ok;
    met_nxt.x         = ax.start;
    met_nxt.y         = ay.start;
    met_nxt.w         = ax.size;
    met_nxt.h         = ay.size;
    met_nxt.d4        = {1'b0, sqx[Dist4W-2:0]} + {1'b0, sqy[Dist4W-2:0]};
    met_nxt.area      = area;
    met_nxt.has_score = cand.has_score;
    met_nxt.score     = cand.score;
    met_nxt.last      = cand.last;
  end

  assign cand_ready = !met_valid_r || met_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      met_valid_r <= 1'b0;
    end else if (cand_ready) begin
      met_valid_r <= cand_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cand_valid && cand_ready) begin
      met_r <= met_nxt;
    end
  end

  assign met_valid = met_valid_r;
  assign met       = met_r;

endmodule

@@ sv/bcs_select.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_select
// Compares each clipped candidate against the kept best and emits the result.
// ----------------------------------------------------------------------------
module bcs_select
  import bcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  sel_mode_t mode,
  input  logic      met_valid,
  input  metric_t   met,
  output logic      met_ready,
  output logic      out_valid,
  output result_t   out_data,
  input  logic      out_ready
);

  logic               have_best_r, have_scored_r;
  logic [27:0]        best_dist4_r;
  logic [26:0]        best_area_r;
  logic signed [31:0] best_score_r;
  logic [PosW-1:0]    best_x_r, best_y_r;
  logic [DimW-1:0]    best_w_r, best_h_r;

  logic      out_valid_r;
  result_t   out_data_r;

  logic      fire;
  logic      closer, take, set_scored;
  logic      have_best_nxt, have_scored_nxt;
  result_t   result_nxt;

  // hold a last request while the result register is still occupied
  assign met_ready = !met.last || !out_valid_r || out_ready;
  assign fire      = met_valid && met_ready;

  always_comb begin
    closer     = !have_best_r || (met.d4 < {2'b00, best_dist4_r});
    take       = 1'b0;
    set_scored = 1'b0;
    unique case (mode)
      MODE_FIRST: begin
        take = !have_best_r;
      end
      MODE_CLOSEST: begin
        take = closer;
      end
      MODE_AREA: begin
        take = !have_best_r || (met.area > {1'b0, best_area_r})
               || ((met.area == {1'b0, best_area_r}) && (met.d4 < {2'b00, best_dist4_r}));
      end
      MODE_SCORE: begin
        if (met.has_score) begin
          take = !have_scored_r || (met.score > best_score_r)
                 || ((met.score == best_score_r) && (met.d4 < {2'b00, best_dist4_r}));
          set_scored = take;
        end else begin
          take = !have_scored_r && closer;
        end
      end
    endcase
    take       = take && met.ok;
    set_scored = set_scored && met.ok;

    have_best_nxt   = have_best_r || take;
    have_scored_nxt = have_scored_r || set_scored;

    // zero the box when nothing was kept
    result_nxt.found  = have_best_nxt;
    result_nxt.left   = !have_best_nxt ? '0 : (take ? met.x[PosW-1:0] : best_x_r);
    result_nxt.top    = !have_best_nxt ? '0 : (take ? met.y[PosW-1:0] : best_y_r);
    result_nxt.width  = !have_best_nxt ? '0 : (take ? met.w : best_w_r);
    result_nxt.height = !have_best_nxt ? '0 : (take ? met.h : best_h_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r   <= 1'b0;
      have_scored_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (fire) begin
        have_best_r   <= met.last ? 1'b0 : have_best_nxt;
        have_scored_r <= met.last ? 1'b0 : have_scored_nxt;
      end
      if (fire && met.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && take) begin
      best_dist4_r <= met.d4[27:0];
      best_area_r  <= met.area[26:0];
      best_x_r     <= met.x[PosW-1:0];
      best_y_r     <= met.y[PosW-1:0];
      best_w_r     <= met.w;
      best_h_r     <= met.h;
    end
    if (fire && set_scored) begin
      best_score_r <= met.score;
    end
    if (fire && met.last) begin
      out_data_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_scored_implies_best: assert property (@(posedge clk) disable iff (!rst_n)
    have_scored_r |-> have_best_r)
    else $error("scored flag set without a kept box");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && met.last) |=> (!have_best_r && !have_scored_r && out_valid_r))
    else $error("state not cleared or result missing after last request");

  a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.found) |-> (out_data_r.width == '0 && out_data_r.height == '0))
    else $error("empty result carries a box");

  a_found_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.found) |-> (out_data_r.width != '0 && out_data_r.height != '0))
    else $error("found result with empty box");

endmodule

@@ sv/bbox_candidate_selector_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbox_candidate_selector_core
// Picks one clipped bounding box out of a stream of candidate boxes.
// ----------------------------------------------------------------------------
// Each candidate request is clipped to the frame (0,0,frame_width,frame_height);
// candidates that clip empty are dropped. The kept box is chosen by select_mode:
// first box, closest center, largest area (nearer wins ties) or highest score
// (scored boxes first, nearer wins ties, nearest unscored box as fallback).
// Center distance is exact, in doubled integer coordinates. On the request
// flagged last_candidate one result request leaves with found and the clipped
// box (all zero when nothing overlapped), and the kept state clears. The block
// takes one candidate every clock cycle unless the result channel holds back a
// last candidate; that one passes the input, metric and result registers. The
// kept best box is compared and updated in the select stage. A frame dimension
// above MAX_FRAME_DIM is clamped to it. Write configuration only while idle.
// ----------------------------------------------------------------------------
module bbox_candidate_selector_core
  import bcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [13:0]        cfg_wdata,
  // candidate channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_box_left,
  input  logic signed [15:0] in_box_top,
  input  logic [14:0]        in_box_width,
  input  logic [14:0]        in_box_height,
  input  logic               in_has_score,
  input  logic signed [31:0] in_score_value,
  input  logic               in_last_candidate,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic [12:0]        out_sel_left,
  output logic [12:0]        out_sel_top,
  output logic [13:0]        out_sel_width,
  output logic [13:0]        out_sel_height
);

  localparam logic [16:0] MaxDim = 17'(MAX_FRAME_DIM);

  sel_mode_t       select_mode_r;
  logic [DimW-1:0] frame_width_r, frame_height_r;
  logic [DimW-1:0] frame_w, frame_h;

  cand_t   cand_r;
  logic    cand_valid_r;
  logic    cand_ready;
  logic    met_valid, met_ready;
  metric_t met;
  result_t out_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      select_mode_r  <= MODE_CLOSEST;
      frame_width_r  <= 14'd1920;
      frame_height_r <= 14'd1080;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SELECT_MODE:  select_mode_r  <= sel_mode_t'(cfg_wdata[1:0]);
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;  // no register at this index, drop the write
      endcase
    end
  end

  // clamp oversized frame dimensions
  assign frame_w = ({3'b000, frame_width_r} > MaxDim) ? MaxDim[DimW-1:0] : frame_width_r;
  assign frame_h = ({3'b000, frame_height_r} > MaxDim) ? MaxDim[DimW-1:0] : frame_height_r;

  // input register: advance when the metric stage can take the request
  assign in_ready = !cand_valid_r || cand_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_valid_r <= 1'b0;
    end else if (in_ready) begin
      cand_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cand_r.left      <= in_box_left;
      cand_r.top       <= in_box_top;
      cand_r.width     <= in_box_width;
      cand_r.height    <= in_box_height;
      cand_r.has_score <= in_has_score;
      cand_r.score     <= in_score_value;
      cand_r.last      <= in_last_candidate;
    end
  end

  bcs_metric u_metric (
    .clk        (clk),
    .rst_n      (rst_n),
    .cand_valid (cand_valid_r),
    .cand       (cand_r),
    .cand_ready (cand_ready),
    .frame_w    (frame_w),
    .frame_h    (frame_h),
    .met_valid  (met_valid),
    .met        (met),
    .met_ready  (met_ready)
  );

  bcs_select u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (select_mode_r),
    .met_valid (met_valid),
    .met       (met),
    .met_ready (met_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_ready (out_ready)
  );

  assign out_found      = out_data.found;
  assign out_sel_left   = out_data.left;
  assign out_sel_top    = out_data.top;
  assign out_sel_width  = out_data.width;
  assign out_sel_height = out_data.height;

endmodule

@@ tb/bbox_candidate_selector_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbox_candidate_selector_core_tb
// Self-checking bench for the bounding box candidate selector.
// ----------------------------------------------------------------------------
// Candidate requests go in through the valid/ready channel. An in-bench
// predictor clips each accepted box to the frame and keeps the best one under
// the current mode. It queues the expected selection on the closing candidate
// of a set. A checker compares every result request with the oldest queued
// selection. Directed tests cover the reset setup, every mode with its tie
// rules, frame limits and a mode switch in the middle of a set. Random phases
// then sweep the frame and mode settings with random gaps on both channels.
// ----------------------------------------------------------------------------
module bbox_candidate_selector_core_tb;
  import bcs_pkg::*;

  localparam longint FRAME_CAP   = 8192;    // frame size clamp of the block
  localparam int     SETTLE_CYC  = 6;       // result latency plus margin
  localparam int     RAND_ITEMS  = 1450;    // random candidates after the directed ones
  localparam int     CYCLE_LIMIT = 400000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [13:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_box_left = '0;
  logic signed [15:0] in_box_top = '0;
  logic [14:0]        in_box_width = '0;
  logic [14:0]        in_box_height = '0;
  logic               in_has_score = 1'b0;
  logic signed [31:0] in_score_value = '0;
  logic               in_last_candidate = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b1;
  logic               out_found;
  logic [12:0]        out_sel_left;
  logic [12:0]        out_sel_top;
  logic [13:0]        out_sel_width;
  logic [13:0]        out_sel_height;

  // Configuration as the bench believes it to be (reset values first)
  sel_mode_t   cur_mode = MODE_CLOSEST;
  logic [13:0] cur_fw = 14'd1920;
  logic [13:0] cur_fh = 14'd1080;

  // Kept-best state of the predictor
  bit                 kept_valid;
  bit                 kept_scored;
  logic [27:0]        kept_dist4;
  logic [26:0]        kept_area;
  logic signed [31:0] kept_score;
  result_t            kept_box;

  // Selections still owed by the block, oldest first
  result_t pending_sel_q[$];

  bit no_idle = 1'b0;   // when set, neither side inserts gaps or stalls
  int ready_hold = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int cand_cnt = 0;
  int usable_cnt = 0;
  int set_cnt = 0;
  int found_cnt = 0;
  int phase_cnt = 0;
  int result_cnt = 0;

  bbox_candidate_selector_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_box_left       (in_box_left),
    .in_box_top        (in_box_top),
    .in_box_width      (in_box_width),
    .in_box_height     (in_box_height),
    .in_has_score      (in_has_score),
    .in_score_value    (in_score_value),
    .in_last_candidate (in_last_candidate),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_sel_left      (out_sel_left),
    .out_sel_top       (out_sel_top),
    .out_sel_width     (out_sel_width),
    .out_sel_height    (out_sel_height)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bound the run; a hang anywhere ends here
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d selections still owed", cycle_cnt,
               pending_sel_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on result %0d, %s: got %0d, expected %0d", result_cnt, what, got, want);
    err_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic longint clamp_dim(input logic [13:0] v);
    return (longint'(v) > FRAME_CAP) ? FRAME_CAP : longint'(v);
  endfunction

  // Clip [lo, lo+len) to [0, lim); an empty span comes back as start 0, size 0
  function automatic void clip_span(input longint lo, input longint len, input longint lim,
                                    output longint start, output longint size);
    longint a;
    longint b;
    a = (lo > 0) ? lo : 0;
    b = lo + len;
    if (b > lim) b = lim;
    if (b > a) begin
      start = a;
      size  = b - a;
    end else begin
      start = 0;
      size  = 0;
    end
  endfunction

  // Fold one accepted candidate into the kept state; queue the selection on the
  // closing candidate. Returns 1 when the candidate overlapped the frame.
  function automatic bit predict_selection(input cand_t c);
    longint  fw, fh, x, y, w, h, dx, dy, d4, area, score;
    bit      hit;
    bit      take;
    result_t r;
    fw = clamp_dim(cur_fw);
    fh = clamp_dim(cur_fh);
    clip_span($signed(c.left), longint'(c.width), fw, x, w);
    clip_span($signed(c.top), longint'(c.height), fh, y, h);
    hit = (w > 0) && (h > 0);
    if (hit) begin
      dx    = 2 * x + w - fw;
      dy    = 2 * y + h - fh;
      d4    = dx * dx + dy * dy;
      area  = w * h;
      score = $signed(c.score);
      take  = 1'b0;
      case (cur_mode)
        MODE_FIRST: begin
          take = !kept_valid;
        end
        MODE_AREA: begin
          take = !kept_valid || area > longint'(kept_area) ||
                 (area == longint'(kept_area) && d4 < longint'(kept_dist4));
        end
        MODE_SCORE: begin
          if (c.has_score) begin
            take = !kept_scored || score > longint'(kept_score) ||
                   (score == longint'(kept_score) && d4 < longint'(kept_dist4));
            if (take) begin
              kept_scored = 1'b1;
              kept_score  = c.score;
            end
          end else begin
            // unscored boxes only count until a scored one shows up
            take = !kept_scored && (!kept_valid || d4 < longint'(kept_dist4));
          end
        end
        default: begin
          take = !kept_valid || d4 < longint'(kept_dist4);
        end
      endcase
      if (take) begin
        kept_valid      = 1'b1;
        kept_dist4      = d4[27:0];
        kept_area       = area[26:0];
        kept_box        = '0;
        kept_box.left   = x[12:0];
        kept_box.top    = y[12:0];
        kept_box.width  = w[13:0];
        kept_box.height = h[13:0];
      end
    end
    if (c.last) begin
      r = '0;
      if (kept_valid) begin
        r       = kept_box;
        r.found = 1'b1;
        found_cnt++;
      end
      pending_sel_q.insert(pending_sel_q.size(), r);
      set_cnt++;
      // the block clears its kept state after each set
      kept_valid  = 1'b0;
      kept_scored = 1'b0;
      kept_dist4  = '0;
      kept_area   = '0;
      kept_score  = '0;
      kept_box    = '0;
    end
    return hit;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stall per result, compare against oldest selection
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_sel_q.size() == 0) begin
        report_mismatch("result with no selection owed, found", out_found, 0);
      end else begin
        result_t want;
        want = pending_sel_q.pop_front();
        if (out_found !== want.found) report_mismatch("found", out_found, want.found);
        if (out_sel_left !== want.left) report_mismatch("sel_left", out_sel_left, want.left);
        if (out_sel_top !== want.top) report_mismatch("sel_top", out_sel_top, want.top);
        if (out_sel_width !== want.width)
          report_mismatch("sel_width", out_sel_width, want.width);
        if (out_sel_height !== want.height)
          report_mismatch("sel_height", out_sel_height, want.height);
      end
      result_cnt++;
      // draw the stall for the next result request
      ready_hold = no_idle ? 0 : $urandom_range(0, 3);
    end else if (rst_n && out_valid && ready_hold > 0) begin
      ready_hold--;
    end
    out_ready <= (ready_hold == 0);
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Send one candidate request: idle a random gap, hold valid until taken
  task automatic send_candidate(input logic signed [15:0] bl, input logic signed [15:0] bt,
                                input logic [14:0] bw, input logic [14:0] bh,
                                input logic scored, input logic signed [31:0] score,
                                input logic last_flag);
    cand_t c;
    int    gap;
    c   = '{bl, bt, bw, bh, scored, score, last_flag};
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_box_left       <= c.left;
    in_box_top        <= c.top;
    in_box_width      <= c.width;
    in_box_height     <= c.height;
    in_has_score      <= c.has_score;
    in_score_value    <= c.score;
    in_last_candidate <= c.last;
    do @(posedge clk); while (!in_ready);
    cand_cnt++;
    if (predict_selection(c)) usable_cnt++;
  endtask

  // Drop valid and hold until every owed selection has come back, then let the
  // pipeline empty of candidates that produce no result
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_sel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Write all three registers back to back while the block is idle
  task automatic write_config(input sel_mode_t mode, input logic [13:0] fw,
                              input logic [13:0] fh);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_SELECT_MODE;
    cfg_wdata <= 14'(mode);
    @(posedge clk);
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_wdata <= fw;
    @(posedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_wdata <= fh;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_mode = mode;
    cur_fw   = fw;
    cur_fh   = fh;
  endtask

  function automatic logic [13:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return 14'd1;
      1:       return 14'd8192;
      2:       return 14'($urandom_range(8193, 16383));   // clamped by the block
      3:       return ($urandom_range(0, 3) == 0) ? 14'd0 : 14'd16;
      4, 5:    return 14'($urandom_range(2, 64));
      default: return 14'($urandom_range(1, 8192));
    endcase
  endfunction

  // One axis of a random box: mostly near the frame, some noise and extremes
  task automatic pick_axis(input int lim, output logic signed [15:0] lo,
                           output logic [14:0] len);
    case ($urandom_range(0, 15))
      0: begin
        lo  = 16'($urandom);
        len = 15'($urandom);
      end
      1: begin
        case ($urandom_range(0, 3))
          0:       lo = -16'sd32768;
          1:       lo = 16'sd32767;
          2:       lo = '0;
          default: lo = 16'(lim - 1);
        endcase
        len = ($urandom_range(0, 1) != 0) ? 15'h7fff : 15'd1;
      end
      2: begin
        lo  = 16'($urandom_range(0, lim));
        len = '0;
      end
      default: begin
        lo  = 16'(int'($urandom_range(0, lim + 4)) - int'($urandom_range(0, lim / 2 + 4)));
        len = 15'($urandom_range(1, lim + 4));
      end
    endcase
  endtask

  function automatic logic signed [31:0] pick_score();
    case ($urandom_range(0, 4))
      0:       return 32'($urandom);
      1:       return 32'(int'($urandom_range(0, 6)) - 3);
      2:       return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
      default: return 32'($urandom_range(0, 4) << 16);   // whole Q16.16 values, many ties
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset setup: closest center in a 1920x1080 frame
  task automatic test_reset_config();
    send_candidate(16'sd100, 16'sd100, 15'd200, 15'd200, 1'b0, 32'sd0, 1'b0);
    send_candidate(16'sd860, 16'sd440, 15'd200, 15'd200, 1'b0, 32'sd0, 1'b0);  // centered
    send_candidate(-16'sd32768, -16'sd32768, 15'h7fff, 15'h7fff, 1'b0, 32'sd0, 1'b0);
    send_candidate(16'sd32767, 16'sd0, 15'd1, 15'd1, 1'b1, 32'sd5, 1'b1);
    // zero-sized box alone: nothing found
    send_candidate(16'sd10, 16'sd10, 15'd0, 15'd5, 1'b0, 32'sd0, 1'b1);
  endtask

  // Same set under every mode, then score ties decided by distance
  task automatic test_each_mode();
    for (int m = 0; m < 4; m++) begin
      write_config(sel_mode_t'(m), 14'd1920, 14'd1080);
      send_candidate(16'sd0, 16'sd0, 15'd100, 15'd100, 1'b1, 32'sd5, 1'b0);
      send_candidate(16'sd900, 16'sd500, 15'd120, 15'd80, 1'b0, 32'sd0, 1'b0);
      send_candidate(-16'sd16, -16'sd16, 15'h7fff, 15'h7fff, 1'b1, -32'sd7, 1'b1);
    end
    send_candidate(16'sd0, 16'sd0, 15'd10, 15'd10, 1'b1, 32'sh7fffffff, 1'b0);
    send_candidate(16'sd955, 16'sd535, 15'd10, 15'd10, 1'b1, 32'sh7fffffff, 1'b0);
    send_candidate(16'sd958, 16'sd538, 15'd4, 15'd4, 1'b0, 32'sd0, 1'b0);
    send_candidate(16'sd960, 16'sd540, 15'd1, 15'd1, 1'b1, 32'sh80000000, 1'b1);
  endtask

  // Zero frame, oversized frame clamp and the one-pixel frame
  task automatic test_frame_limits();
    write_config(MODE_CLOSEST, 14'd0, 14'd1080);
    send_candidate(16'sd0, 16'sd0, 15'd100, 15'd100, 1'b0, 32'sd0, 1'b1);
    write_config(MODE_AREA, 14'h3fff, 14'd8193);
    send_candidate(-16'sd5, 16'sd8000, 15'h7fff, 15'h7fff, 1'b0, 32'sd0, 1'b1);
    write_config(MODE_FIRST, 14'd1, 14'd1);
    send_candidate(-16'sd1, -16'sd1, 15'd1, 15'd1, 1'b0, 32'sd0, 1'b0);
    send_candidate(16'sd0, 16'sd0, 15'd1, 15'd1, 1'b1, -32'sd1, 1'b1);
  endtask

  // Change the mode while a set is open; each candidate follows its own mode
  task automatic test_mode_switch_in_set();
    write_config(MODE_AREA, 14'd640, 14'd480);
    send_candidate(16'sd0, 16'sd0, 15'd50, 15'd50, 1'b1, 32'sd3, 1'b0);
    send_candidate(16'sd300, 16'sd200, 15'd40, 15'd40, 1'b0, 32'sd0, 1'b0);
    write_config(MODE_SCORE, 14'd640, 14'd480);
    send_candidate(16'sd600, 16'sd400, 15'd10, 15'd10, 1'b1, -32'sd100, 1'b0);
    write_config(MODE_FIRST, 14'd640, 14'd480);
    send_candidate(16'sd0, 16'sd0, 15'd640, 15'd480, 1'b1, 32'sd0, 1'b1);
  endtask

  // Random phases: new settings each phase, sets of random length that may
  // straddle a phase boundary, repeated boxes to force area and distance ties
  task automatic test_random_sets();
    int                 cand_start;
    int                 phase_len;
    int                 set_left;
    int                 fw;
    int                 fh;
    logic signed [15:0] bl, bt;
    logic [14:0]        bw, bh;
    logic signed [15:0] prev_l, prev_t;
    logic [14:0]        prev_w, prev_h;
    cand_start = cand_cnt;
    set_left   = 0;
    prev_l = '0;
    prev_t = '0;
    prev_w = 15'd1;
    prev_h = 15'd1;
    while (cand_cnt - cand_start < RAND_ITEMS) begin
      write_config(sel_mode_t'($urandom_range(0, 3)), pick_dim(), pick_dim());
      no_idle   = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(40, 160);
      fw        = int'(clamp_dim(cur_fw));
      fh        = int'(clamp_dim(cur_fh));
      for (int i = 0; i < phase_len && cand_cnt - cand_start < RAND_ITEMS; i++) begin
        if (set_left == 0)
          set_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        set_left--;
        if ($urandom_range(0, 7) == 0) begin
          bl = prev_l;
          bt = prev_t;
          bw = prev_w;
          bh = prev_h;
        end else begin
          pick_axis(fw, bl, bw);
          pick_axis(fh, bt, bh);
        end
        prev_l = bl;
        prev_t = bt;
        prev_w = bw;
        prev_h = bh;
        send_candidate(bl, bt, bw, bh, $urandom_range(0, 2) != 0, pick_score(),
                       set_left == 0);
      end
      phase_cnt++;
    end
    // close any open set so its selection is checked too
    no_idle = 1'b0;
    if (set_left != 0)
      send_candidate(16'sd0, 16'sd0, 15'd1, 15'd1, 1'b0, 32'sd0, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_config();
    test_each_mode();
    test_frame_limits();
    test_mode_switch_in_set();
    test_random_sets();
    drain();
    $display("ran %0d candidate requests (%0d overlapping the frame) in %0d sets, %0d found",
             cand_cnt, usable_cnt, set_cnt, found_cnt);
    $display("checked %0d selections over %0d random settings phases", result_cnt, phase_cnt);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
